@@ src/arpc_pkg.sv @@
// Shared types, constants and codes for the ARP cache block.
`default_nettype none

package arpc_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int MAC_W  = 48;
   localparam int IP_W   = 32;
   localparam int STAT_W = 3;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // register indexes on the configuration port
   localparam logic [1:0] REG_OWN_MAC      = 2'd0;
   localparam logic [1:0] REG_OWN_IP       = 2'd1;
   localparam logic [1:0] REG_OWN_IP_VALID = 2'd2;

   // request opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // packet field codes
   localparam logic [15:0] HW_ETHERNET  = 16'h0001;
   localparam logic [15:0] PROTO_IPV4   = 16'h0800;
   localparam logic [15:0] OPER_REQUEST = 16'h0001;
   localparam logic [15:0] OPER_REPLY   = 16'h0002;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADTYPE = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

   typedef struct packed {
      logic [MAC_W-1:0] own_mac;
      logic [IP_W-1:0]  own_ip;
      logic             own_ip_valid;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } tbl_wr_type;

   typedef struct packed {
      logic             occ;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } tbl_rd_type;

endpackage

`default_nettype wire

@@ src/arpc_csr.sv @@
// Configuration register file with APB-style access.
`default_nettype none

module arpc_csr
   import arpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:3];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_OWN_MAC:      cfg_in.own_mac      = pwdata[MAC_W-1:0];
            REG_OWN_IP:       cfg_in.own_ip       = pwdata[IP_W-1:0];
            REG_OWN_IP_VALID: cfg_in.own_ip_valid = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OWN_MAC:      prdata = {{(CSR_DATA_W-MAC_W){1'b0}}, cfg_ff.own_mac};
         REG_OWN_IP:       prdata = {{(CSR_DATA_W-IP_W){1'b0}}, cfg_ff.own_ip};
         REG_OWN_IP_VALID: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.own_ip_valid};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/arpc_table.sv @@
// Address table memory with occupancy flags and registered read port.
`default_nettype none

module arpc_table
   import arpc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] rd_addr,
   input  wire tbl_wr_type       wr,
   output tbl_rd_type            rd
);

   logic [IP_W-1:0]  ip_mem_ff  [ENTRIES];
   logic [MAC_W-1:0] mac_mem_ff [ENTRIES];
   logic [ENTRIES-1:0] occ_ff;
   logic [ENTRIES-1:0] occ_in;
   tbl_rd_type         rd_ff;

   always_comb begin
      occ_in = occ_ff;
      if (wr.en) begin
         occ_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= {{(ENTRIES-1){1'b0}}, 1'b1};
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ip_mem_ff[wr.idx]  <= wr.ip;
         mac_mem_ff[wr.idx] <= wr.mac;
      end
   end

   // slot zero holds the broadcast pair for good
   always_ff @(posedge clock) begin
      rd_ff.occ <= occ_ff[rd_addr];
      if (rd_addr == '0) begin
         rd_ff.ip  <= '1;
         rd_ff.mac <= '1;
      end else begin
         rd_ff.ip  <= ip_mem_ff[rd_addr];
         rd_ff.mac <= mac_mem_ff[rd_addr];
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

@@ src/arpc_seq.sv @@
// Scan sequencer with shared key comparator and result registers.
`default_nettype none

module arpc_seq
   import arpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              opcode,
   input  wire logic [15:0]       hw_type,
   input  wire logic [15:0]       proto_type,
   input  wire logic [15:0]       arp_op,
   input  wire logic [MAC_W-1:0]  sender_mac,
   input  wire logic [IP_W-1:0]   sender_ip,
   input  wire logic [IP_W-1:0]   lookup_ip,
   input  wire cfg_type           cfg,
   output logic [IDX_W-1:0]       rd_addr,
   input  wire tbl_rd_type        rd,
   output tbl_wr_type             wr,
   output logic                   rsp_strobe,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [MAC_W-1:0]       rsp_found_mac,
   output logic                   rsp_reply_valid,
   output logic [MAC_W-1:0]       rsp_reply_dst_mac,
   output logic [IP_W-1:0]        rsp_reply_dst_ip,
   output logic [MAC_W-1:0]       rsp_reply_src_mac,
   output logic [IP_W-1:0]        rsp_reply_src_ip
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type         state_ff, state_in;
   logic              learn_ff, learn_in;
   logic              is_req_ff, is_req_in;
   logic [MAC_W-1:0]  key_ff, key_in;
   logic [IP_W-1:0]   sip_ff, sip_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_last_ff, rd_last_in;
   logic              have_free_ff, have_free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   logic              strobe_ff, strobe_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [MAC_W-1:0]  found_ff, found_in;
   logic              rvalid_ff, rvalid_in;
   logic [MAC_W-1:0]  rdmac_ff, rdmac_in;
   logic [IP_W-1:0]   rdip_ff, rdip_in;
   logic [MAC_W-1:0]  rsmac_ff, rsmac_in;
   logic [IP_W-1:0]   rsip_ff, rsip_in;

   logic [MAC_W-1:0]  cmp_data;
   logic              hit;
   logic              reply;
   logic              free_any;

   // shared comparator: IP field on lookup, MAC field on learning
   assign cmp_data = learn_ff ? rd.mac : {{(MAC_W-IP_W){1'b0}}, rd.ip};
   assign hit      = rd_vld_ff & rd.occ & (cmp_data == key_ff);
   assign reply    = learn_ff & is_req_ff & cfg.own_ip_valid;
   assign free_any = have_free_ff | ~rd.occ;

   always_comb begin
      state_in     = state_ff;
      learn_in     = learn_ff;
      is_req_in    = is_req_ff;
      key_in       = key_ff;
      sip_in       = sip_ff;
      addr_in      = addr_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      rd_last_in   = rd_last_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      found_in     = found_ff;
      rvalid_in    = rvalid_ff;
      rdmac_in     = rdmac_ff;
      rdip_in      = rdip_ff;
      rsmac_in     = rsmac_ff;
      rsip_in      = rsip_ff;
      wr           = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in      = '0;
               rd_vld_in    = 1'b0;
               rd_last_in   = 1'b0;
               have_free_in = 1'b0;
               is_req_in    = (arp_op == OPER_REQUEST);
               sip_in       = sender_ip;
               found_in     = '0;
               rvalid_in    = 1'b0;
               rdmac_in     = '0;
               rdip_in      = '0;
               rsmac_in     = '0;
               rsip_in      = '0;
               if (opcode == OP_LOOKUP) begin
                  learn_in = 1'b0;
                  key_in   = {{(MAC_W-IP_W){1'b0}}, lookup_ip};
                  state_in = S_SCAN;
               end else if (hw_type != HW_ETHERNET || proto_type != PROTO_IPV4) begin
                  strobe_in = 1'b1;
                  status_in = ST_BADTYPE;
               end else if (arp_op == OPER_REQUEST || arp_op == OPER_REPLY) begin
                  learn_in = 1'b1;
                  key_in   = sender_mac;
                  state_in = S_SCAN;
               end else begin
                  strobe_in = 1'b1;
                  status_in = ST_IGNORED;
               end
            end
         end

         S_SCAN: begin
            addr_in    = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
            rd_vld_in  = 1'b1;
            rd_idx_in  = addr_ff;
            rd_last_in = (addr_ff == LAST_IDX);
            if (rd_vld_ff) begin
               if (!rd.occ && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = rd_idx_ff;
               end
               if (hit || rd_last_ff) begin
                  state_in  = S_IDLE;
                  strobe_in = 1'b1;
                  rvalid_in = reply;
                  rdmac_in  = reply ? key_ff : '0;
                  rdip_in   = reply ? sip_ff : '0;
                  rsmac_in  = reply ? cfg.own_mac : '0;
                  rsip_in   = reply ? cfg.own_ip : '0;
                  if (hit) begin
                     status_in = ST_OK;
                     found_in  = learn_ff ? '0 : rd.mac;
                  end else if (!learn_ff) begin
                     status_in = ST_MISS;
                     found_in  = '0;
                  end else if (free_any) begin
                     status_in = ST_OK;
                     found_in  = '0;
                     wr.en     = 1'b1;
                     wr.idx    = have_free_ff ? free_idx_ff : rd_idx_ff;
                     wr.ip     = sip_ff;
                     wr.mac    = key_ff;
                  end else begin
                     status_in = ST_FULL;
                     found_in  = '0;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      learn_ff     <= learn_in;
      is_req_ff    <= is_req_in;
      key_ff       <= key_in;
      sip_ff       <= sip_in;
      addr_ff      <= addr_in;
      rd_vld_ff    <= rd_vld_in;
      rd_idx_ff    <= rd_idx_in;
      rd_last_ff   <= rd_last_in;
      have_free_ff <= have_free_in;
      free_idx_ff  <= free_idx_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      rvalid_ff    <= rvalid_in;
      rdmac_ff     <= rdmac_in;
      rdip_ff      <= rdip_in;
      rsmac_ff     <= rsmac_in;
      rsip_ff      <= rsip_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rd_addr           = addr_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_found_mac     = found_ff;
   assign rsp_reply_valid   = rvalid_ff;
   assign rsp_reply_dst_mac = rdmac_ff;
   assign rsp_reply_dst_ip  = rdip_ff;
   assign rsp_reply_src_mac = rsmac_ff;
   assign rsp_reply_src_ip  = rsip_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> state_ff == S_IDLE)
      else $error("result word while scan in progress");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || strobe_ff))
      else $error("accepted word neither scanned nor answered");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> (strobe_ff && status_ff == ST_OK && found_ff == '0))
      else $error("table write without done status");

   a_reply_learn: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rvalid_ff) |-> (status_ff == ST_OK || status_ff == ST_FULL))
      else $error("reply on a word that was not learned");

endmodule

`default_nettype wire

@@ src/arp_cache_learn_lookup_reply.sv @@
// Top level of the ARP cache: learning, lookup and reply generation.
//
//   channel   direction  handshake                 payload
//   request   in         start high, busy low      req_opcode .. req_lookup_ip
//   result    out        rsp_strobe, one cycle     rsp_status .. rsp_reply_src_ip
//   config    in/out     psel, penable, pwrite     paddr, pwdata, prdata (64 bits)
//
// A lookup or learned packet scans the table one slot a cycle through the
// registered memory read port, until a hit or the last slot.
// Bad-type and ignored-op packets answer the cycle after accept.
// busy stays high for the whole scan; the result strobe comes with busy low.
// Reset is synchronous; the table comes up with only the broadcast slot used.
// The result receiver cannot stall.
`default_nettype none

module arp_cache_learn_lookup_reply
   import arpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_opcode,
   input  wire logic [15:0]           req_hw_type,
   input  wire logic [15:0]           req_proto_type,
   input  wire logic [15:0]           req_arp_op,
   input  wire logic [MAC_W-1:0]      req_sender_mac,
   input  wire logic [IP_W-1:0]       req_sender_ip,
   input  wire logic [IP_W-1:0]       req_lookup_ip,
   output logic                       rsp_strobe,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [MAC_W-1:0]           rsp_found_mac,
   output logic                       rsp_reply_valid,
   output logic [MAC_W-1:0]           rsp_reply_dst_mac,
   output logic [IP_W-1:0]            rsp_reply_dst_ip,
   output logic [MAC_W-1:0]           rsp_reply_src_mac,
   output logic [IP_W-1:0]            rsp_reply_src_ip
);

   cfg_type          cfg;
   logic [IDX_W-1:0] rd_addr;
   tbl_rd_type       tbl_rd;
   tbl_wr_type       tbl_wr;

   arpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arpc_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr      (tbl_wr),
      .rd      (tbl_rd)
   );

   arpc_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .opcode            (req_opcode),
      .hw_type           (req_hw_type),
      .proto_type        (req_proto_type),
      .arp_op            (req_arp_op),
      .sender_mac        (req_sender_mac),
      .sender_ip         (req_sender_ip),
      .lookup_ip         (req_lookup_ip),
      .cfg               (cfg),
      .rd_addr           (rd_addr),
      .rd                (tbl_rd),
      .wr                (tbl_wr),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_found_mac     (rsp_found_mac),
      .rsp_reply_valid   (rsp_reply_valid),
      .rsp_reply_dst_mac (rsp_reply_dst_mac),
      .rsp_reply_dst_ip  (rsp_reply_dst_ip),
      .rsp_reply_src_mac (rsp_reply_src_mac),
      .rsp_reply_src_ip  (rsp_reply_src_ip)
   );

endmodule

`default_nettype wire
